### sv/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg - shared types and constants for the Cartesian tree builder
// Holds the field widths, the request kinds, the controller state and
// command codes, and the status bundle passed from datapath to controller.
// ----------------------------------------------------------------------------
package ctb_pkg;

    localparam int MAX_NODES_DEF  = 256;
    localparam int VALUE_BITS_DEF = 32;
    localparam int LINK_BITS      = 9;
    localparam int POS_BITS       = 8;
    localparam int KIND_BITS      = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_APPEND = 2'd0,
        KIND_READ   = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STK_RD,
        ST_TOP_RD,
        ST_CMP,
        ST_RIGHT_RD,
        ST_WR1,
        ST_WR2,
        ST_RES_APP,
        ST_Q_RD,
        ST_Q_CMP,
        ST_NODE_RD,
        ST_RES_NODE,
        ST_RES_FAIL
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_APP_START,
        OP_READ_START,
        OP_QUERY_START,
        OP_STK_RD,
        OP_TOP_RD,
        OP_POP,
        OP_KEEP,
        OP_RIGHT_RD,
        OP_WR1,
        OP_WR2,
        OP_Q_RD,
        OP_Q_CMP,
        OP_NODE_RD,
        OP_RES_APP,
        OP_RES_NODE,
        OP_RES_FAIL
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  app_full;
        logic  depth_zero;
        logic  depth_one;
        logic  read_ok;
        logic  range_ok;
        logic  keeps;
        logic  k_last;
        logic  out_free;
    } status_t;

endpackage

### sv/ctb_ctrl.sv
// ----------------------------------------------------------------------------
// ctb_ctrl - sequencing state machine
// Steps each request through its memory reads and writes and hands the
// datapath one command per cycle.
// ----------------------------------------------------------------------------
module ctb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ctb_pkg::status_t status,
    output ctb_pkg::cmd_t    cmd
);

    ctb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ctb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = ctb_pkg::OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ctb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = ctb_pkg::OP_LATCH;
                    state_next = ctb_pkg::ST_DECODE;
                end
            end
            ctb_pkg::ST_DECODE: begin
                unique case (status.kind)
                    ctb_pkg::KIND_APPEND: begin
                        cmd.op = ctb_pkg::OP_APP_START;
                        if (status.app_full) begin
                            state_next = ctb_pkg::ST_RES_FAIL;
                        end else if (status.depth_zero) begin
                            state_next = ctb_pkg::ST_WR1;
                        end else begin
                            state_next = ctb_pkg::ST_STK_RD;
                        end
                    end
                    ctb_pkg::KIND_READ: begin
                        if (status.read_ok) begin
                            cmd.op     = ctb_pkg::OP_READ_START;
                            state_next = ctb_pkg::ST_NODE_RD;
                        end else begin
                            state_next = ctb_pkg::ST_RES_FAIL;
                        end
                    end
                    ctb_pkg::KIND_QUERY: begin
                        if (status.range_ok) begin
                            cmd.op     = ctb_pkg::OP_QUERY_START;
                            state_next = ctb_pkg::ST_Q_RD;
                        end else begin
                            state_next = ctb_pkg::ST_RES_FAIL;
                        end
                    end
                    default: begin
                        state_next = ctb_pkg::ST_RES_FAIL;
                    end
                endcase
            end
            ctb_pkg::ST_STK_RD: begin
                cmd.op     = ctb_pkg::OP_STK_RD;
                state_next = ctb_pkg::ST_TOP_RD;
            end
            ctb_pkg::ST_TOP_RD: begin
                cmd.op     = ctb_pkg::OP_TOP_RD;
                state_next = ctb_pkg::ST_CMP;
            end
            ctb_pkg::ST_CMP: begin
                if (status.keeps) begin
                    cmd.op     = ctb_pkg::OP_KEEP;
                    state_next = ctb_pkg::ST_RIGHT_RD;
                end else begin
                    cmd.op     = ctb_pkg::OP_POP;
                    state_next = status.depth_one ? ctb_pkg::ST_WR1 : ctb_pkg::ST_STK_RD;
                end
            end
            ctb_pkg::ST_RIGHT_RD: begin
                cmd.op     = ctb_pkg::OP_RIGHT_RD;
                state_next = ctb_pkg::ST_WR1;
            end
            ctb_pkg::ST_WR1: begin
                cmd.op     = ctb_pkg::OP_WR1;
                state_next = ctb_pkg::ST_WR2;
            end
            ctb_pkg::ST_WR2: begin
                cmd.op     = ctb_pkg::OP_WR2;
                state_next = ctb_pkg::ST_RES_APP;
            end
            ctb_pkg::ST_RES_APP: begin
                if (status.out_free) begin
                    cmd.op     = ctb_pkg::OP_RES_APP;
                    state_next = ctb_pkg::ST_IDLE;
                end
            end
            ctb_pkg::ST_Q_RD: begin
                cmd.op     = ctb_pkg::OP_Q_RD;
                state_next = ctb_pkg::ST_Q_CMP;
            end
            ctb_pkg::ST_Q_CMP: begin
                cmd.op     = ctb_pkg::OP_Q_CMP;
                state_next = status.k_last ? ctb_pkg::ST_NODE_RD : ctb_pkg::ST_Q_RD;
            end
            ctb_pkg::ST_NODE_RD: begin
                cmd.op     = ctb_pkg::OP_NODE_RD;
                state_next = ctb_pkg::ST_RES_NODE;
            end
            ctb_pkg::ST_RES_NODE: begin
                if (status.out_free) begin
                    cmd.op     = ctb_pkg::OP_RES_NODE;
                    state_next = ctb_pkg::ST_IDLE;
                end
            end
            ctb_pkg::ST_RES_FAIL: begin
                if (status.out_free) begin
                    cmd.op     = ctb_pkg::OP_RES_FAIL;
                    state_next = ctb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ctb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/ctb_dpath.sv
// ----------------------------------------------------------------------------
// ctb_dpath - node stores, spine stack and result register
// Holds the tree memories and working registers and carries out one
// controller command per cycle.
// ----------------------------------------------------------------------------
module ctb_dpath #(
    parameter int MAX_NODES  = ctb_pkg::MAX_NODES_DEF,
    parameter int VALUE_BITS = ctb_pkg::VALUE_BITS_DEF,
    localparam int IN_W  = ((ctb_pkg::KIND_BITS + 1 + VALUE_BITS + 2 * ctb_pkg::POS_BITS + 7)
                            / 8) * 8,
    localparam int OUT_W = ((5 * ctb_pkg::LINK_BITS + VALUE_BITS + 1 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    input  ctb_pkg::cmd_t    cmd,
    output ctb_pkg::status_t status
);

    localparam int IW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int LW   = IW + 1;
    localparam int CMPW = ((CW > ctb_pkg::POS_BITS) ? CW : ctb_pkg::POS_BITS) + 1;
    localparam int LB   = ctb_pkg::LINK_BITS;
    localparam int PAD  = OUT_W - (5 * LB + VALUE_BITS + 1);
    localparam int VLO  = ctb_pkg::KIND_BITS + 1;
    localparam int ALO  = VLO + VALUE_BITS;
    localparam int BLO  = ALO + ctb_pkg::POS_BITS;

    localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};

    function automatic logic keeps_order(input logic mh,
                                         input logic signed [VALUE_BITS-1:0] up,
                                         input logic signed [VALUE_BITS-1:0] lo);
        return mh ? (up >= lo) : (up <= lo);
    endfunction

    function automatic logic [LB-1:0] to_link(input logic [LW-1:0] lk);
        return lk[IW] ? {LB{1'b1}} : LB'(lk[IW-1:0]);
    endfunction

    // memories
    logic signed [VALUE_BITS-1:0] val_mem [MAX_NODES];
    logic [LW-1:0]                par_mem [MAX_NODES];
    logic [LW-1:0]                lft_mem [MAX_NODES];
    logic [LW-1:0]                rgt_mem [MAX_NODES];
    logic [IW-1:0]                stk_mem [MAX_NODES];

    logic signed [VALUE_BITS-1:0] val_q;
    logic [LW-1:0]                par_q, lft_q, rgt_q;
    logic [IW-1:0]                stk_q;

    // request registers
    ctb_pkg::kind_t               kind_reg;
    logic                         first_reg;
    logic signed [VALUE_BITS-1:0] v_reg;
    logic [ctb_pkg::POS_BITS-1:0] a_reg, b_reg;
    logic                         max_heap_reg;

    // tree state
    logic [CW-1:0] count_reg, depth_reg;
    logic [LW-1:0] root_reg;

    // working registers
    logic [IW-1:0]                i_reg, top_reg, p_reg, k_reg, best_reg, node_addr_reg;
    logic [LW-1:0]                last_reg, child_reg;
    logic                         root_case_reg;
    logic signed [VALUE_BITS-1:0] best_val_reg;

    // result register
    logic                         out_valid_reg;
    logic [LB-1:0]                o_idx_reg, o_par_reg, o_lft_reg, o_rgt_reg, o_root_reg;
    logic signed [VALUE_BITS-1:0] o_val_reg;
    logic                         o_ok_reg;

    logic [LW-1:0] child_w;
    logic [IW-1:0] best_w;
    logic          take_k;

    assign child_w = root_case_reg ? last_reg : rgt_q;
    assign take_k  = (k_reg == IW'(a_reg)) || !keeps_order(max_heap_reg, best_val_reg, val_q);
    assign best_w  = take_k ? k_reg : best_reg;

    always_comb begin
        status.kind       = kind_reg;
        status.app_full   = !first_reg && (count_reg == CW'(MAX_NODES));
        status.depth_zero = first_reg || (depth_reg == '0);
        status.depth_one  = (depth_reg == CW'(1));
        status.read_ok    = CMPW'(a_reg) < CMPW'(count_reg);
        status.range_ok   = (a_reg <= b_reg) && (CMPW'(b_reg) < CMPW'(count_reg));
        status.keeps      = keeps_order(max_heap_reg, val_q, v_reg);
        status.k_last     = CMPW'(k_reg) == CMPW'(b_reg);
        status.out_free   = !out_valid_reg || m_tready;
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (cmd.op == ctb_pkg::OP_WR1) begin
            val_mem[i_reg] <= v_reg;
            lft_mem[i_reg] <= child_w;
            rgt_mem[i_reg] <= NIL;
            stk_mem[IW'(depth_reg)] <= i_reg;
        end
        if (cmd.op == ctb_pkg::OP_WR1) begin
            par_mem[i_reg] <= root_case_reg ? NIL : {1'b0, p_reg};
        end else if (cmd.op == ctb_pkg::OP_WR2 && !child_reg[IW]) begin
            par_mem[child_reg[IW-1:0]] <= {1'b0, i_reg};
        end
        if (cmd.op == ctb_pkg::OP_WR2 && !root_case_reg) begin
            rgt_mem[p_reg] <= {1'b0, i_reg};
        end
        case (cmd.op)
            ctb_pkg::OP_STK_RD:  stk_q <= stk_mem[IW'(depth_reg - CW'(1))];
            ctb_pkg::OP_TOP_RD:  val_q <= val_mem[stk_q];
            ctb_pkg::OP_Q_RD:    val_q <= val_mem[k_reg];
            ctb_pkg::OP_RIGHT_RD: rgt_q <= rgt_mem[p_reg];
            ctb_pkg::OP_NODE_RD: begin
                val_q <= val_mem[node_addr_reg];
                par_q <= par_mem[node_addr_reg];
                lft_q <= lft_mem[node_addr_reg];
                rgt_q <= rgt_mem[node_addr_reg];
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            depth_reg     <= '0;
            root_reg      <= NIL;
            max_heap_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_heap_reg <= cfg_wdata;
            end
            case (cmd.op)
                ctb_pkg::OP_APP_START: begin
                    if (first_reg) begin
                        count_reg <= '0;
                        depth_reg <= '0;
                        root_reg  <= NIL;
                    end
                end
                ctb_pkg::OP_POP: depth_reg <= depth_reg - CW'(1);
                ctb_pkg::OP_WR1: begin
                    depth_reg <= depth_reg + CW'(1);
                    count_reg <= count_reg + CW'(1);
                    if (root_case_reg) begin
                        root_reg <= {1'b0, i_reg};
                    end
                end
                default: ;
            endcase
            if (cmd.op == ctb_pkg::OP_RES_APP || cmd.op == ctb_pkg::OP_RES_NODE
                || cmd.op == ctb_pkg::OP_RES_FAIL) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            ctb_pkg::OP_LATCH: begin
                kind_reg  <= ctb_pkg::kind_t'(s_tdata[ctb_pkg::KIND_BITS-1:0]);
                first_reg <= s_tdata[ctb_pkg::KIND_BITS];
                v_reg     <= s_tdata[ALO-1:VLO];
                a_reg     <= s_tdata[BLO-1:ALO];
                b_reg     <= s_tdata[BLO+ctb_pkg::POS_BITS-1:BLO];
            end
            ctb_pkg::OP_APP_START: begin
                i_reg         <= first_reg ? '0 : IW'(count_reg);
                root_case_reg <= 1'b1;
                last_reg      <= NIL;
            end
            ctb_pkg::OP_TOP_RD: top_reg <= stk_q;
            ctb_pkg::OP_POP:    last_reg <= {1'b0, top_reg};
            ctb_pkg::OP_KEEP: begin
                p_reg         <= top_reg;
                root_case_reg <= 1'b0;
            end
            ctb_pkg::OP_WR1:        child_reg <= child_w;
            ctb_pkg::OP_READ_START: node_addr_reg <= IW'(a_reg);
            ctb_pkg::OP_QUERY_START: k_reg <= IW'(a_reg);
            ctb_pkg::OP_Q_CMP: begin
                best_reg      <= best_w;
                node_addr_reg <= best_w;
                if (take_k) begin
                    best_val_reg <= val_q;
                end
                k_reg <= k_reg + IW'(1);
            end
            ctb_pkg::OP_RES_APP: begin
                o_idx_reg  <= LB'(i_reg);
                o_val_reg  <= v_reg;
                o_par_reg  <= root_case_reg ? {LB{1'b1}} : LB'(p_reg);
                o_lft_reg  <= to_link(child_reg);
                o_rgt_reg  <= {LB{1'b1}};
                o_root_reg <= to_link(root_reg);
                o_ok_reg   <= 1'b1;
            end
            ctb_pkg::OP_RES_NODE: begin
                o_idx_reg  <= LB'(node_addr_reg);
                o_val_reg  <= val_q;
                o_par_reg  <= to_link(par_q);
                o_lft_reg  <= to_link(lft_q);
                o_rgt_reg  <= to_link(rgt_q);
                o_root_reg <= to_link(root_reg);
                o_ok_reg   <= 1'b1;
            end
            ctb_pkg::OP_RES_FAIL: begin
                o_idx_reg  <= {LB{1'b1}};
                o_val_reg  <= '0;
                o_par_reg  <= {LB{1'b1}};
                o_lft_reg  <= {LB{1'b1}};
                o_rgt_reg  <= {LB{1'b1}};
                o_root_reg <= to_link(root_reg);
                o_ok_reg   <= 1'b0;
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD{1'b0}}, o_ok_reg, o_root_reg, o_rgt_reg, o_lft_reg, o_par_reg,
                       o_val_reg, o_idx_reg};

endmodule

### sv/cartesian_tree_builder_rmq.sv
// ----------------------------------------------------------------------------
// cartesian_tree_builder_rmq - Cartesian tree builder with range queries
// Builds a min- or max-heap Cartesian tree from appended values and answers
// node reads and leftmost range-extreme queries.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request beat on s_* (kind, first, value, position_a/b); one
//   result beat comes back on m_* for every request, in order.
//   cfg_we/cfg_wdata write max_heap (0 min-heap, 1 max-heap); write it only
//   while no request is in flight.
// Steps after acceptance and decode, until m_tvalid rises:
//   append : with first clear and a non-empty spine, a stack read, value
//            read and compare per spine node examined, a right-link read if
//            a parent remains; then two node writes, the result. Each node is
//            popped at most once, so pops amortise to under one per append.
//   read   : node read, result.  failure (bad index, range, full, kind 3):
//            result.  query: a read on the shared value-store port and a
//            compare per node in the range, then node read and result.
// Throughput: one request at a time; s_tready is high only when the engine
//   is idle. The result sits in an output register, so the next request is
//   taken while the previous result still waits.
// Stall: with m_tready low the result beat holds and the next request's
//   result waits in the engine until the register frees.
// Reset: aresetn low empties the tree (root -1) and selects min-heap; the
//   node stores are not cleared, only entries below the node count are read.
// ----------------------------------------------------------------------------
module cartesian_tree_builder_rmq #(
    parameter int MAX_NODES  = ctb_pkg::MAX_NODES_DEF,
    parameter int VALUE_BITS = ctb_pkg::VALUE_BITS_DEF,
    localparam int IN_W  = ((ctb_pkg::KIND_BITS + 1 + VALUE_BITS + 2 * ctb_pkg::POS_BITS + 7)
                            / 8) * 8,
    localparam int OUT_W = ((5 * ctb_pkg::LINK_BITS + VALUE_BITS + 1 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // kind[1:0], first, value, position_a, position_b, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // node_index, node_value, parent_link, left_link, right_link, root_index,
    // ok, zero pad
    output logic [OUT_W-1:0] m_tdata
);

    localparam int LB     = ctb_pkg::LINK_BITS;
    localparam int PAR_LO = LB + VALUE_BITS;
    localparam int OK_BIT = 5 * LB + VALUE_BITS;

    ctb_pkg::cmd_t    cmd;
    ctb_pkg::status_t status;

    // sequencer: one command per cycle
    ctb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // stores, stack, working and result registers
    ctb_dpath #(
        .MAX_NODES  (MAX_NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef SYNTH
    // one request at a time: ready drops right after a beat is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while engine busy");

    // a failed result names no node
    a_fail_no_node: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[OK_BIT] |-> m_tdata[LB-1:0] == {LB{1'b1}})
        else $error("failed result carries a node index");

    // a node is never its own parent
    a_parent_differs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OK_BIT] |-> m_tdata[PAR_LO+LB-1:PAR_LO] != m_tdata[LB-1:0])
        else $error("node reported as its own parent");
`endif

endmodule

### test/cartesian_tree_builder_rmq_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_tree_builder_rmq_test - self-checking bench for the tree builder
// Drives append, read and range-query beats with bursty sending and a
// stalling receiver, and predicts every result beat from a local copy of the
// tree (stores, spine stack, root, count and heap mode). Results are checked
// field by field, in order.
// ----------------------------------------------------------------------------
module cartesian_tree_builder_rmq_test;

    localparam int NODES = 256;
    localparam int IN_W  = 56;
    localparam int OUT_W = 80;

    typedef struct {
        logic signed [8:0]  node_index;
        logic signed [31:0] node_value;
        logic signed [8:0]  parent_link;
        logic signed [8:0]  left_link;
        logic signed [8:0]  right_link;
        logic signed [8:0]  root_index;
        logic               ok;
    } tree_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_wdata = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // kind[1:0], first, value[31:0], position_a[7:0], position_b[7:0], zero pad
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // node_index, node_value, parent_link, left_link, right_link, root_index,
    // ok, zero pad
    logic [OUT_W-1:0] m_tdata;

    cartesian_tree_builder_rmq dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Local copy of the tree, kept in step with every accepted beat
    int  tree_value [NODES];
    int  tree_parent [NODES];
    int  tree_left [NODES];
    int  tree_right [NODES];
    int  spine [NODES];
    int  spine_depth = 0;
    int  node_total = 0;
    int  tree_root = -1;
    bit  max_mode = 1'b0;

    tree_result_t pending_results[$];
    int  errors = 0;
    int  beats_sent = 0;
    int  beats_checked = 0;
    int  query_count = 0;
    int  full_rejects = 0;

    // Sender burst shaping
    int  burst_left = 0;
    int  gap_len = 0;

    // Receiver stall pattern and long hold-off requests
    int  rx_mode = 0;
    int  rx_phase = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;

    // True when the upper node may stay an ancestor of the lower one
    function automatic bit heap_ok(int upper, int lower);
        return max_mode ? (upper >= lower) : (upper <= lower);
    endfunction

    function automatic tree_result_t node_result(int idx, bit good);
        tree_result_t r;
        if (good && idx >= 0 && idx < node_total) begin
            r.node_index  = 9'(idx);
            r.node_value  = tree_value[idx];
            r.parent_link = 9'(tree_parent[idx]);
            r.left_link   = 9'(tree_left[idx]);
            r.right_link  = 9'(tree_right[idx]);
            r.ok          = 1'b1;
        end else begin
            r.node_index  = -9'sd1;
            r.node_value  = 0;
            r.parent_link = -9'sd1;
            r.left_link   = -9'sd1;
            r.right_link  = -9'sd1;
            r.ok          = 1'b0;
        end
        r.root_index = 9'(tree_root);
        return r;
    endfunction

    // Work out the result of one beat and advance the local tree
    function automatic tree_result_t tree_step(ctb_pkg::kind_t kind, bit first, int value,
                                               int pos_a, int pos_b);
        int idx;
        int last;
        int top;
        int best;
        if (kind == ctb_pkg::KIND_APPEND) begin
            if (first) begin
                node_total = 0;
                spine_depth = 0;
                tree_root = -1;
            end
            if (node_total >= NODES) begin
                full_rejects++;
                return node_result(-1, 1'b0);
            end
            idx = node_total;
            last = -1;
            tree_value[idx] = value;
            tree_parent[idx] = -1;
            tree_left[idx] = -1;
            tree_right[idx] = -1;
            // pop every spine node that breaks heap order
            while (spine_depth > 0) begin
                top = spine[spine_depth-1];
                if (heap_ok(tree_value[top], value)) break;
                last = top;
                spine_depth--;
            end
            if (spine_depth > 0) begin
                top = spine[spine_depth-1];
                tree_parent[idx] = top;
                tree_left[idx] = tree_right[top];
                if (tree_right[top] >= 0) tree_parent[tree_right[top]] = idx;
                tree_right[top] = idx;
            end else begin
                tree_left[idx] = last;
                if (last >= 0) tree_parent[last] = idx;
                tree_root = idx;
            end
            spine[spine_depth] = idx;
            spine_depth++;
            node_total = idx + 1;
            return node_result(idx, 1'b1);
        end else if (kind == ctb_pkg::KIND_READ) begin
            return node_result(pos_a, pos_a < node_total);
        end else if (kind == ctb_pkg::KIND_QUERY) begin
            query_count++;
            if (pos_a <= pos_b && pos_b < node_total) begin
                best = pos_a;
                for (int k = pos_a + 1; k <= pos_b; k++)
                    if (!heap_ok(tree_value[best], tree_value[k])) best = k;
                return node_result(best, 1'b1);
            end
            return node_result(-1, 1'b0);
        end
        return node_result(-1, 1'b0);
    endfunction

    // Offer one beat, hold it until taken, then log its expected result
    task automatic send_beat(ctb_pkg::kind_t kind, bit first, int value, int pos_a,
                             int pos_b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_len > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, pos_b[7:0], pos_a[7:0], value, first, 2'(kind)};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(tree_step(kind, first, value, pos_a, pos_b));
        beats_sent++;
    endtask

    // Drop valid and wait for every outstanding result, plus a short margin
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_mode(bit mode);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        max_mode = mode;
    endtask

    // Mix of full-range, tie-prone, and extreme Q16.16 values
    function automatic int pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return int'($urandom);
            5, 6, 7:       return ($urandom_range(0, 8) - 4) <<< 16;
            8:             return 32'sh8000_0000;
            default:       return 32'sh7fff_ffff;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compare each accepted beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        tree_result_t want;
        tree_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.node_index  = m_tdata[8:0];
            got.node_value  = m_tdata[40:9];
            got.parent_link = m_tdata[49:41];
            got.left_link   = m_tdata[58:50];
            got.right_link  = m_tdata[67:59];
            got.root_index  = m_tdata[76:68];
            got.ok          = m_tdata[77];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, data %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                beats_checked++;
                if (got.node_index !== want.node_index) begin
                    $display("%0t: node_index expected %0d actual %0d",
                             $time, want.node_index, got.node_index);
                    errors++;
                end
                if (got.node_value !== want.node_value) begin
                    $display("%0t: node_value expected %h actual %h",
                             $time, want.node_value, got.node_value);
                    errors++;
                end
                if (got.parent_link !== want.parent_link) begin
                    $display("%0t: parent_link expected %0d actual %0d",
                             $time, want.parent_link, got.parent_link);
                    errors++;
                end
                if (got.left_link !== want.left_link) begin
                    $display("%0t: left_link expected %0d actual %0d",
                             $time, want.left_link, got.left_link);
                    errors++;
                end
                if (got.right_link !== want.right_link) begin
                    $display("%0t: right_link expected %0d actual %0d",
                             $time, want.right_link, got.right_link);
                    errors++;
                end
                if (got.root_index !== want.root_index) begin
                    $display("%0t: root_index expected %0d actual %0d",
                             $time, want.root_index, got.root_index);
                    errors++;
                end
                if (got.ok !== want.ok) begin
                    $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern chosen by rx_mode, long holds on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (rx_phase % 5) < 2;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, ties, every kind and every failure path but a full tree
    task automatic test_directed();
        send_beat(ctb_pkg::KIND_READ, 1'b0, 0, 0, 0);                 // read on empty tree (first run)
        send_beat(ctb_pkg::KIND_QUERY, 1'b0, 0, 0, 0);                // query on empty tree (first run)
        send_beat(ctb_pkg::KIND_APPEND, 1'b0, 5 <<< 16, 0, 0);        // append with first low
        send_beat(ctb_pkg::KIND_APPEND, 1'b0, 5 <<< 16, 0, 0);        // tie: earlier stays above
        send_beat(ctb_pkg::KIND_APPEND, 1'b0, 32'sh8000_0000, 0, 0);  // first run: pops all, new root
        send_beat(ctb_pkg::KIND_APPEND, 1'b0, 32'sh7fff_ffff, 0, 0);
        send_beat(ctb_pkg::KIND_APPEND, 1'b0, 0, 0, 0);
        send_beat(ctb_pkg::KIND_APPEND, 1'b0, -1, 0, 0);
        send_beat(ctb_pkg::KIND_READ, 1'b0, 0, 0, 255);
        send_beat(ctb_pkg::KIND_READ, 1'b0, 0, 5, 0);
        send_beat(ctb_pkg::KIND_READ, 1'b0, 0, 6, 0);                 // index past count (first run)
        send_beat(ctb_pkg::KIND_READ, 1'b0, 0, 255, 255);
        send_beat(ctb_pkg::KIND_QUERY, 1'b0, 0, 0, 5);
        send_beat(ctb_pkg::KIND_QUERY, 1'b0, 0, 0, 1);                // leftmost of a tie (first run)
        send_beat(ctb_pkg::KIND_QUERY, 1'b0, 0, 3, 3);                // single-node range
        send_beat(ctb_pkg::KIND_QUERY, 1'b0, 0, 4, 2);                // reversed bounds
        send_beat(ctb_pkg::KIND_QUERY, 1'b0, 0, 0, 6);                // right bound past count (first run)
        send_beat(ctb_pkg::KIND_QUERY, 1'b0, 0, 255, 255);
        send_beat(ctb_pkg::KIND_NONE, 1'b1, -1, 255, 255);            // unknown kind
        send_beat(ctb_pkg::KIND_APPEND, 1'b1, 32'sh0001_8000, 0, 0);  // restart sequence
        send_beat(ctb_pkg::KIND_READ, 1'b0, 0, 1, 0);                 // stale node after restart
        drain();
    endtask

    // Fill to capacity, overflow, then clear with first
    task automatic test_full_tree();
        for (int i = 0; i < NODES; i++)
            send_beat(ctb_pkg::KIND_APPEND, i == 0, pick_value(), 0, 0);
        send_beat(ctb_pkg::KIND_APPEND, 1'b0, 1, 0, 0);
        send_beat(ctb_pkg::KIND_QUERY, 1'b0, 0, 0, 255);
        send_beat(ctb_pkg::KIND_READ, 1'b0, 0, 255, 0);
        send_beat(ctb_pkg::KIND_APPEND, 1'b1, 7, 0, 0);
        drain();
    endtask

    // Build under max-heap, then flip to min-heap with the tree in place
    task automatic test_mode_change();
        write_mode(1'b1);
        for (int i = 0; i < 12; i++)
            send_beat(ctb_pkg::KIND_APPEND, i == 0, pick_value(), 0, 0);
        send_beat(ctb_pkg::KIND_QUERY, 1'b0, 0, 0, 11);
        write_mode(1'b0);
        send_beat(ctb_pkg::KIND_QUERY, 1'b0, 0, 0, 11);
        send_beat(ctb_pkg::KIND_APPEND, 1'b0, pick_value(), 0, 0);
        send_beat(ctb_pkg::KIND_READ, 1'b0, 0, 12, 0);
        drain();
    endtask

    // Hold the receiver off while the sender keeps offering beats
    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 20; i++)
            send_beat(i % 3 == 0 ? ctb_pkg::KIND_APPEND : ctb_pkg::KIND_READ, i == 0,
                      pick_value(), i / 3, 0);
        drain();
    endtask

    // Random sequences: appends with reads and queries woven in
    task automatic test_random(int beats);
        int seq_len;
        int a;
        int b;
        while (beats_sent < beats) begin
            if ($urandom_range(0, 7) == 0) write_mode(1'($urandom_range(0, 1)));
            rx_mode = $urandom_range(0, 2);
            seq_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 255)
                                                    : $urandom_range(1, 40);
            for (int i = 0; i < seq_len; i++) begin
                send_beat(ctb_pkg::KIND_APPEND, i == 0 && $urandom_range(0, 9) != 0,
                          pick_value(), 0, 0);
                if ($urandom_range(0, 2) == 0) begin
                    a = $urandom_range(0, node_total - 1);
                    b = $urandom_range(a, ($urandom_range(0, 3) == 0)
                                          ? node_total - 1 : a + 8);
                    if (b >= node_total) b = node_total - 1;
                    case ($urandom_range(0, 9))
                        0:       send_beat(ctb_pkg::KIND_NONE, $urandom_range(0, 1),
                                           pick_value(), $urandom_range(0, 255),
                                           $urandom_range(0, 255));
                        1, 2:    send_beat(ctb_pkg::KIND_READ, $urandom_range(0, 1),
                                           pick_value(),
                                           ($urandom_range(0, 3) == 0)
                                           ? $urandom_range(0, 255) : a,
                                           $urandom_range(0, 255));
                        3:       send_beat(ctb_pkg::KIND_QUERY, $urandom_range(0, 1),
                                           pick_value(), $urandom_range(0, 255),
                                           $urandom_range(0, 255));
                        default: send_beat(ctb_pkg::KIND_QUERY, $urandom_range(0, 1),
                                           pick_value(), a, b);
                    endcase
                end
            end
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_mode(1'b0);
        test_directed();
        test_full_tree();
        test_mode_change();
        test_backpressure();
        write_mode(1'b1);
        test_directed();
        test_random(1750);
        $display("Covered %0d beats, %0d results checked, %0d range queries, %0d rejects.",
                 beats_sent, beats_checked, query_count, full_rejects);
        $display("Both heap modes, ties, capacity overflow and a long receiver hold were exercised.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("cartesian_tree_builder_rmq test passed");
        end else begin
            $display("cartesian_tree_builder_rmq test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("cartesian_tree_builder_rmq test failed");
        $finish;
    end

endmodule
